// File: rtl/assert_macros.svh
// Assertion macros for the top level, which checks its own behavior.
// Every check is clocked on aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// An implication: whenever trig holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bfsp_pkg.sv
// Shared constants, types and functions of the shortest-path core.
// No dependencies; used by the controller, the datapath and the top level.
package bfsp_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 1024;

    localparam int VERT_FW   = 6;   // vertex field width
    localparam int COUNT_FW  = 7;   // vertex_count register width
    localparam int WEIGHT_W  = 16;  // edge weight width
    localparam int DIST_W    = 26;  // distance width
    localparam int PRED_W    = 7;   // predecessor width
    localparam int EDGE_W    = 2 * VERT_FW + WEIGHT_W;
    localparam int ROW_W     = DIST_W + PRED_W + WEIGHT_W;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 56;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX = 1'd1;

    localparam logic [PRED_W-1:0]   PRED_NONE = 7'd64;
    localparam logic [COUNT_FW-1:0] VCOUNT_RESET = 7'd64;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 26'sh1FFFFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 26'sh2000000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic load_drop;
        logic init_we;
        logic edge_latch;
        logic edge_cmp;
        logic copy_we;
        logic out_load;
        logic clear_run;
    } bfsp_cmd_t;

    // Clamp a sum that grew by one bit back into the distance range.
    function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [DIST_W:0] x);
        logic signed [DIST_W:0] hi;
        logic signed [DIST_W:0] lo;
        hi = DIST_W'(DIST_MAX);
        lo = {1'b1, DIST_MIN};
        if (x > hi) begin
            return DIST_MAX;
        end else if (x < lo) begin
            return DIST_MIN;
        end else begin
            return x[DIST_W-1:0];
        end
    endfunction

endpackage

// File: rtl/bfsp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/bfsp_datapath.sv
// Datapath of the shortest-path core: edge store, distance stores, weight sum,
// relaxation compare and the result register. Depends on bfsp_pkg, bfsp_ram.
module bfsp_datapath #(
    parameter int MAX_VERTICES = bfsp_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = bfsp_pkg::DEF_MAX_EDGES,
    parameter int VCW = $clog2(MAX_VERTICES + 1),
    parameter int ECW = $clog2(MAX_EDGES + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bfsp_pkg::bfsp_cmd_t             cmd,
    input  logic [ECW-1:0]                  edge_addr,
    input  logic [VCW-1:0]                  vidx,
    input  logic [VCW-1:0]                  n_eff,
    input  logic [bfsp_pkg::VERT_FW-1:0]    start_v,
    input  logic [bfsp_pkg::EDGE_W-1:0]     in_rec,
    output logic [bfsp_pkg::M_DATA_W-1:0]   out_data
);
    import bfsp_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VW  = $clog2(MAX_VERTICES);

    logic signed [DIST_W-1:0] wsum_reg, wsum_next;
    logic                     drop_reg, drop_next;

    logic [EDGE_W-1:0] edge_rdata;
    logic [VERT_FW-1:0] e_src_reg, e_nbr_reg;
    logic signed [WEIGHT_W-1:0] e_w_reg;

    logic signed [DIST_W-1:0] old_rdata;
    logic [ROW_W-1:0]  new_rdata;
    logic [ROW_W-1:0]  new_wdata;
    logic [VW-1:0]     new_waddr, new_raddr;
    logic              new_we;
    logic [DIST_W-1:0] old_wdata;
    logic              old_we;

    logic signed [DIST_W-1:0] init_dist, cand, cur_dist;
    logic [PRED_W-1:0]        init_pred;
    logic                     is_start, e_ok, improve;
    logic signed [WEIGHT_W-1:0] in_w;

    logic [VERT_FW-1:0]  o_vertex_reg;
    logic [DIST_W-1:0]   o_dist_reg;
    logic [PRED_W-1:0]   o_pred_reg;
    logic [WEIGHT_W-1:0] o_w_reg;
    logic                o_ovf_reg;

    assign in_w = in_rec[EDGE_W-1:2*VERT_FW];

    // Weight sum and drop flag are the per-graph running state.
    always_comb begin
        wsum_next = wsum_reg;
        drop_next = drop_reg;
        if (cmd.clear_run) begin
            wsum_next = '0;
            drop_next = 1'b0;
        end else if (cmd.load_we) begin
            wsum_next = sat_dist((DIST_W+1)'(wsum_reg) + (DIST_W+1)'(in_w));
        end else if (cmd.load_drop) begin
            drop_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsum_reg <= '0;
            drop_reg <= 1'b0;
        end else begin
            wsum_reg <= wsum_next;
            drop_reg <= drop_next;
        end
    end

    bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
        .aclk  (aclk),
        .we    (cmd.load_we),
        .waddr (edge_addr[EAW-1:0]),
        .wdata (in_rec),
        .raddr (edge_addr[EAW-1:0]),
        .rdata (edge_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.edge_latch) begin
            e_src_reg <= edge_rdata[VERT_FW-1:0];
            e_nbr_reg <= edge_rdata[2*VERT_FW-1:VERT_FW];
            e_w_reg   <= edge_rdata[EDGE_W-1:2*VERT_FW];
        end
    end

    assign is_start  = (COUNT_FW'(vidx) == COUNT_FW'(start_v));
    assign init_dist = is_start ? '0 : wsum_reg;
    assign init_pred = is_start ? PRED_W'(start_v) : PRED_NONE;

    assign cur_dist = new_rdata[DIST_W-1:0];
    assign cand     = sat_dist((DIST_W+1)'(old_rdata) + (DIST_W+1)'(e_w_reg));
    assign e_ok     = (COUNT_FW'(e_src_reg) < COUNT_FW'(n_eff))
                   && (COUNT_FW'(e_nbr_reg) < COUNT_FW'(n_eff));
    assign improve  = cmd.edge_cmp && e_ok && (cand < cur_dist);

    always_comb begin
        new_we    = cmd.init_we || improve;
        new_waddr = cmd.init_we ? vidx[VW-1:0] : e_src_reg[VW-1:0];
        new_wdata = cmd.init_we ? {{WEIGHT_W{1'b0}}, init_pred, init_dist}
                                : {e_w_reg, PRED_W'(e_nbr_reg), cand};
        new_raddr = cmd.edge_latch ? edge_rdata[VW-1:0] : vidx[VW-1:0];
        old_we    = cmd.init_we || cmd.copy_we;
        old_wdata = cmd.init_we ? init_dist : cur_dist;
    end

    bfsp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES), .AW(VW)) u_new_ram (
        .aclk  (aclk),
        .we    (new_we),
        .waddr (new_waddr),
        .wdata (new_wdata),
        .raddr (new_raddr),
        .rdata (new_rdata)
    );

    bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES), .AW(VW)) u_old_ram (
        .aclk  (aclk),
        .we    (old_we),
        .waddr (vidx[VW-1:0]),
        .wdata (old_wdata),
        .raddr (edge_rdata[VERT_FW+VW-1:VERT_FW]),
        .rdata (old_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_vertex_reg <= VERT_FW'(vidx);
            o_dist_reg   <= cur_dist;
            o_pred_reg   <= new_rdata[DIST_W+PRED_W-1:DIST_W];
            o_w_reg      <= new_rdata[ROW_W-1:DIST_W+PRED_W];
            o_ovf_reg    <= drop_reg;
        end
    end

    assign out_data = {o_ovf_reg, o_w_reg, o_pred_reg, o_dist_reg, o_vertex_reg};
endmodule

// File: rtl/bfsp_ctrl.sv
// Controller of the shortest-path core: configuration registers, sequencer
// and loop counters. Depends on bfsp_pkg.
module bfsp_ctrl #(
    parameter int MAX_VERTICES = bfsp_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = bfsp_pkg::DEF_MAX_EDGES,
    parameter int VCW = $clog2(MAX_VERTICES + 1),
    parameter int ECW = $clog2(MAX_EDGES + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfsp_pkg::COUNT_FW-1:0]    cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tlast,
    output logic                             s_tready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             m_tlast,
    output bfsp_pkg::bfsp_cmd_t              cmd,
    output logic [ECW-1:0]                   edge_addr,
    output logic [VCW-1:0]                   vidx,
    output logic [VCW-1:0]                   n_eff,
    output logic [bfsp_pkg::VERT_FW-1:0]     start_v
);
    import bfsp_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_RCHK  = 4'd2;
    localparam logic [3:0] S_EADDR = 4'd3;
    localparam logic [3:0] S_EDATA = 4'd4;
    localparam logic [3:0] S_ECMP  = 4'd5;
    localparam logic [3:0] S_CADDR = 4'd6;
    localparam logic [3:0] S_CWR   = 4'd7;
    localparam logic [3:0] S_OADDR = 4'd8;
    localparam logic [3:0] S_ODATA = 4'd9;
    localparam logic [3:0] S_OHOLD = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [COUNT_FW-1:0] vcount_reg;
    logic [VERT_FW-1:0]  start_reg;
    logic [ECW-1:0]      etot_reg, etot_next;
    logic [ECW-1:0]      e_reg, e_next;
    logic [VCW-1:0]      v_reg, v_next;
    logic [VCW-1:0]      r_reg, r_next;
    logic                mvalid_reg, mvalid_next;
    logic                v_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
            start_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VERTEX_COUNT: vcount_reg <= cfg_wdata;
                REG_START_VERTEX: start_reg  <= cfg_wdata[VERT_FW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (vcount_reg == '0) begin
            n_eff = VCW'(1);
        end else if (vcount_reg > COUNT_FW'(MAX_VERTICES)) begin
            n_eff = VCW'(MAX_VERTICES);
        end else begin
            n_eff = VCW'(vcount_reg);
        end
    end

    assign start_v   = start_reg;
    assign v_last    = (v_reg + VCW'(1)) == n_eff;
    assign s_tready  = (state_reg == S_LOAD);
    assign m_tvalid  = mvalid_reg;
    assign m_tlast   = v_last;
    assign vidx      = v_reg;
    assign edge_addr = (state_reg == S_LOAD) ? etot_reg : e_reg;

    always_comb begin
        state_next  = state_reg;
        etot_next   = etot_reg;
        e_next      = e_reg;
        v_next      = v_reg;
        r_next      = r_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        unique case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    if (etot_reg < ECW'(MAX_EDGES)) begin
                        cmd.load_we = 1'b1;
                        etot_next   = etot_reg + ECW'(1);
                    end else begin
                        cmd.load_drop = 1'b1;
                    end
                    if (s_tlast) begin
                        v_next     = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.init_we = 1'b1;
                v_next      = v_reg + VCW'(1);
                if (v_last) begin
                    r_next     = VCW'(1);
                    state_next = S_RCHK;
                end
            end
            S_RCHK: begin
                e_next = '0;
                v_next = '0;
                if (r_reg >= n_eff) begin
                    state_next = S_OADDR;
                end else if (etot_reg == '0) begin
                    state_next = S_CADDR;
                end else begin
                    state_next = S_EADDR;
                end
            end
            S_EADDR: state_next = S_EDATA;
            S_EDATA: begin
                cmd.edge_latch = 1'b1;
                state_next     = S_ECMP;
            end
            S_ECMP: begin
                cmd.edge_cmp = 1'b1;
                e_next       = e_reg + ECW'(1);
                state_next   = (e_reg + ECW'(1) == etot_reg) ? S_CADDR : S_EADDR;
            end
            S_CADDR: state_next = S_CWR;
            S_CWR: begin
                cmd.copy_we = 1'b1;
                if (v_last) begin
                    r_next     = r_reg + VCW'(1);
                    state_next = S_RCHK;
                end else begin
                    v_next     = v_reg + VCW'(1);
                    state_next = S_CADDR;
                end
            end
            S_OADDR: state_next = S_ODATA;
            S_ODATA: begin
                cmd.out_load = 1'b1;
                mvalid_next  = 1'b1;
                state_next   = S_OHOLD;
            end
            S_OHOLD: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    if (v_last) begin
                        cmd.clear_run = 1'b1;
                        etot_next     = '0;
                        state_next    = S_LOAD;
                    end else begin
                        v_next     = v_reg + VCW'(1);
                        state_next = S_OADDR;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            etot_reg   <= '0;
            e_reg      <= '0;
            v_reg      <= '0;
            r_reg      <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            etot_reg   <= etot_next;
            e_reg      <= e_next;
            v_reg      <= v_next;
            r_reg      <= r_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// File: rtl/bellman_ford_shortest_paths_core.sv
// Top level of the Bellman-Ford shortest-path core: controller plus datapath.
// Depends on bfsp_pkg, bfsp_ctrl, bfsp_datapath, bfsp_ram, assert_macros.svh.
//
// Edge records stream in on the s_ side at one beat per cycle and are kept in
// an edge RAM of MAX_EDGES entries; records that do not fit are dropped and
// the results of that graph carry the overflow flag. The beat with s_tlast set
// starts the solve, during which s_tready stays low. With n vertices and E
// stored edges the solve first initializes every vertex, then runs n-1 rounds
// in which every edge passes through S_EADDR, S_EDATA and S_ECMP because its
// record, then the two distances it names, come out of registered RAM ports
// before the compare-and-write. After that one result beat per vertex goes
// out on the m_ side, each after a RAM read, a load of the output register
// and the handshake, m_tlast marking the last. The core then returns to
// taking edge records. Configuration writes (vertex_count at index 0,
// start_vertex at index 1) belong between graphs.
module bellman_ford_shortest_paths_core #(
    parameter int MAX_VERTICES = bfsp_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = bfsp_pkg::DEF_MAX_EDGES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfsp_pkg::COUNT_FW-1:0]    cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // from_vertex[5:0], neighbor_vertex[11:6], edge_weight[27:12], zero pad
    input  logic [bfsp_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // vertex[5:0], distance[31:6], predecessor[38:32],
    // tree_edge_weight[54:39], overflow[55]
    output logic [bfsp_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);
    import bfsp_pkg::*;

    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int ECW = $clog2(MAX_EDGES + 1);

    bfsp_cmd_t          cmd;
    logic [ECW-1:0]     edge_addr;
    logic [VCW-1:0]     vidx;
    logic [VCW-1:0]     n_eff;
    logic [VERT_FW-1:0] start_v;

    bfsp_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .VCW          (VCW),
        .ECW          (ECW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .edge_addr (edge_addr),
        .vidx      (vidx),
        .n_eff     (n_eff),
        .start_v   (start_v)
    );

    bfsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .VCW          (VCW),
        .ECW          (ECW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .edge_addr (edge_addr),
        .vidx      (vidx),
        .n_eff     (n_eff),
        .start_v   (start_v),
        .in_rec    (s_tdata[EDGE_W-1:0]),
        .out_data  (m_tdata)
    );

`include "assert_macros.svh"

    // Loading and result delivery never overlap.
    `ASSERT_CLK(a_no_overlap, !(s_tready && m_tvalid), "input and output active together")
    // The closing edge record starts the solve and input stops at once.
    `ASSERT_NEXT(a_last_stops_in, s_tvalid && s_tready && s_tlast, !s_tready, "input open after last")
    // After the final result beat the core takes edge records again.
    `ASSERT_NEXT(a_back_to_load, m_tvalid && m_tready && m_tlast, s_tready, "no return to loading")
endmodule

// File: tb/bfsp_path_checker.sv
// Watches the edge, result and register-write channels of the shortest-path core.
// It predicts every result beat and compares it. Depends on bfsp_pkg.
module bfsp_path_checker
    import bfsp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COUNT_FW-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    paths_pending
);

    localparam int EDGE_CAP = DEF_MAX_EDGES;

    typedef struct {
        logic [VERT_FW-1:0]        vertex;
        logic signed [DIST_W-1:0]  distance;
        logic [PRED_W-1:0]         pred;
        logic signed [WEIGHT_W-1:0] tree_w;
        logic                      overflow;
        logic                      last;
    } path_row_t;

    path_row_t path_rows[$];

    logic [VERT_FW-1:0]   edge_src[EDGE_CAP];
    logic [VERT_FW-1:0]   edge_nbr[EDGE_CAP];
    longint               edge_w[EDGE_CAP];
    int                   edge_cnt;
    longint               weight_total;
    bit                   records_dropped;
    logic [COUNT_FW-1:0]  vcount_reg;
    logic [VERT_FW-1:0]   start_reg;

    assign paths_pending = path_rows.size();

    function automatic longint clamp_dist(input longint x);
        if (x > 64'sd33554431) return 64'sd33554431;
        if (x < -64'sd33554432) return -64'sd33554432;
        return x;
    endfunction

    // Jacobi relaxation over the stored edges, then one row per vertex.
    task automatic solve_graph();
        int n;
        longint d_old[64];
        longint d_new[64];
        logic [PRED_W-1:0] pr[64];
        longint cw[64];
        longint cand;
        path_row_t row;
        n = vcount_reg;
        if (n == 0) n = 1;
        if (n > 64) n = 64;
        for (int v = 0; v < n; v++) begin
            d_old[v] = weight_total;
            pr[v] = PRED_NONE;
            cw[v] = 0;
        end
        if (start_reg < n) begin
            d_old[start_reg] = 0;
            pr[start_reg] = PRED_W'(start_reg);
        end
        for (int v = 0; v < n; v++) d_new[v] = d_old[v];
        for (int r = 1; r < n; r++) begin
            for (int e = 0; e < edge_cnt; e++) begin
                if (edge_src[e] >= n || edge_nbr[e] >= n) continue;
                cand = clamp_dist(d_old[edge_nbr[e]] + edge_w[e]);
                if (cand < d_new[edge_src[e]]) begin
                    d_new[edge_src[e]] = cand;
                    pr[edge_src[e]] = PRED_W'(edge_nbr[e]);
                    cw[edge_src[e]] = edge_w[e];
                end
            end
            for (int v = 0; v < n; v++) d_old[v] = d_new[v];
        end
        for (int v = 0; v < n; v++) begin
            row.vertex = VERT_FW'(v);
            row.distance = d_old[v][DIST_W-1:0];
            row.pred = pr[v];
            row.tree_w = cw[v][WEIGHT_W-1:0];
            row.overflow = records_dropped;
            row.last = (v + 1 == n);
            path_rows.push_back(row);
        end
        edge_cnt = 0;
        weight_total = 0;
        records_dropped = 0;
    endtask

    task automatic compare_row();
        path_row_t row;
        if (path_rows.size() == 0) begin
            $error("result beat for vertex %0d with no result expected", m_tdata[5:0]);
            mismatch_count++;
            return;
        end
        row = path_rows.pop_front();
        if (m_tdata[5:0] !== row.vertex) begin
            $error("vertex: expected %0d, got %0d", row.vertex, m_tdata[5:0]);
            mismatch_count++;
        end
        if (m_tdata[31:6] !== row.distance) begin
            $error("distance: expected %0d, got %0d", row.distance, $signed(m_tdata[31:6]));
            mismatch_count++;
        end
        if (m_tdata[38:32] !== row.pred) begin
            $error("predecessor: expected %0d, got %0d", row.pred, m_tdata[38:32]);
            mismatch_count++;
        end
        if (m_tdata[54:39] !== row.tree_w) begin
            $error("tree_edge_weight: expected %0d, got %0d", row.tree_w,
                   $signed(m_tdata[54:39]));
            mismatch_count++;
        end
        if (m_tdata[55] !== row.overflow) begin
            $error("overflow: expected %0b, got %0b", row.overflow, m_tdata[55]);
            mismatch_count++;
        end
        if (m_tlast !== row.last) begin
            $error("last_result: expected %0b, got %0b", row.last, m_tlast);
            mismatch_count++;
        end
    endtask

    initial mismatch_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            edge_cnt = 0;
            weight_total = 0;
            records_dropped = 0;
            vcount_reg = VCOUNT_RESET;
            start_reg = '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_VERTEX_COUNT) vcount_reg = cfg_wdata;
                else if (cfg_index == REG_START_VERTEX) start_reg = cfg_wdata[VERT_FW-1:0];
            end
            if (s_tvalid && s_tready) begin
                if (edge_cnt < EDGE_CAP) begin
                    edge_src[edge_cnt] = s_tdata[5:0];
                    edge_nbr[edge_cnt] = s_tdata[11:6];
                    edge_w[edge_cnt] = longint'($signed(s_tdata[27:12]));
                    weight_total = clamp_dist(weight_total + edge_w[edge_cnt]);
                    edge_cnt++;
                end else begin
                    records_dropped = 1;
                end
                if (s_tlast) solve_graph();
            end
            if (m_tvalid && m_tready) compare_row();
        end
    end

endmodule

// File: tb/bellman_ford_shortest_paths_core_test.sv
// Top of the shortest-path core testbench: clock, reset, stimulus and verdict.
// Depends on bfsp_pkg, bfsp_path_checker and the core itself.
module bellman_ford_shortest_paths_core_test;
    import bfsp_pkg::*;

    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT = 3000000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_VERTEX_COUNT;
    logic [COUNT_FW-1:0]  cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;

    int mismatch_count;
    int paths_pending;
    int cycle_count = 0;
    // Percentage of cycles in which each side holds off; zero for a calm stretch.
    int idle_pct = 16;
    int graph_verts = 64;
    int random_beats = 0;
    int graph_idx = 0;

    always #5 aclk = ~aclk;

    bellman_ford_shortest_paths_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    bfsp_path_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .mismatch_count(mismatch_count), .paths_pending(paths_pending)
    );

    // The result side stalls at random, changing only on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog: a hung core must still end the run with a verdict.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bellman_ford_shortest_paths_core_test: FAIL");
            $finish;
        end
    end

    // Sends one edge record. Called and returning at a falling edge, so the
    // valid line gets exactly one assignment per step even across beats.
    task automatic send_edge(input int from_v, input int nbr_v, input int w, input bit last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, 16'(w), 6'(nbr_v), 6'(from_v)};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Holds the sender until every predicted result beat has gone out, then
    // lets the core settle back into loading.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (paths_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Register writes only happen after drain_results, with the core idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= COUNT_FW'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Picks a vertex mostly inside the active count, sometimes anywhere.
    function automatic int pick_vertex();
        if ($urandom_range(99) < 85) return $urandom_range(graph_verts - 1);
        return $urandom_range(63);
    endfunction

    function automatic int pick_weight();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return $urandom_range(1) ? 32767 : -32768;
        if (sel < 5) return $urandom_range(250) - 50;
        return int'($signed(16'($urandom)));
    endfunction

    initial begin
        int n_edges;
        int cfg_val;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration (64 vertices, start 0) with field extremes.
        graph_verts = 64;
        send_edge(63, 0, 32767, 0);
        send_edge(0, 63, -32768, 0);
        send_edge(1, 0, 5, 0);
        send_edge(2, 1, -3, 1);
        drain_results();

        // Small graph from vertex 2: a tie between identical edges, a chain,
        // and a record whose vertex lies beyond the count.
        write_reg(REG_VERTEX_COUNT, 5);
        write_reg(REG_START_VERTEX, 2);
        send_edge(3, 2, 4, 0);
        send_edge(3, 2, 4, 0);
        send_edge(4, 3, -7, 0);
        send_edge(1, 4, 2, 0);
        send_edge(10, 1, 7, 0);
        send_edge(0, 1, 0, 1);
        drain_results();

        // A count of zero behaves as one vertex.
        write_reg(REG_VERTEX_COUNT, 0);
        write_reg(REG_START_VERTEX, 0);
        send_edge(0, 0, -1, 1);
        drain_results();

        // The largest count saturates to 64; the start is the top vertex.
        write_reg(REG_VERTEX_COUNT, 127);
        write_reg(REG_START_VERTEX, 63);
        send_edge(62, 63, -100, 0);
        send_edge(0, 62, 30000, 1);
        drain_results();

        // Start vertex outside the count: nothing is seeded with zero.
        write_reg(REG_VERTEX_COUNT, 4);
        write_reg(REG_START_VERTEX, 9);
        send_edge(1, 0, -5, 0);
        send_edge(2, 1, 3, 1);
        drain_results();

        // Random graphs, mostly small, with an occasional change of settings.
        while (random_beats < 400) begin
            idle_pct = (graph_idx >= 6 && graph_idx < 12) ? 0 : 16;
            if (graph_idx % 3 == 0) begin
                drain_results();
                cfg_val = ($urandom_range(9) == 0) ? $urandom_range(127)
                                                   : $urandom_range(1, 10);
                write_reg(REG_VERTEX_COUNT, cfg_val);
                graph_verts = (cfg_val == 0) ? 1 : (cfg_val > 64 ? 64 : cfg_val);
                write_reg(REG_START_VERTEX, ($urandom_range(9) == 0) ? $urandom_range(63)
                                                   : $urandom_range(graph_verts));
            end
            n_edges = $urandom_range(1, 14);
            for (int i = 0; i < n_edges; i++) begin
                send_edge(pick_vertex(), pick_vertex(), pick_weight(), i == n_edges - 1);
                random_beats++;
            end
            graph_idx++;
        end

        drain_results();
        repeat (50) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("bellman_ford_shortest_paths_core_test: PASS");
        end else begin
            $display("bellman_ford_shortest_paths_core_test: FAIL");
        end
        $finish;
    end

endmodule
